/* rtl/aer_pkg.sv */
// Shared types, constants and helper functions for the auto exposure regulator.
// Used by aer_update and auto_exposure_regulator_unit; depends on nothing else.
package aer_pkg;

    localparam int SumWidth      = 18;
    localparam int MeanShift     = 10;
    localparam int GridCount     = 32;
    localparam int GridRowFirst  = 8;
    localparam int GridRowStep   = 27;
    localparam int GridByteFirst = 20;
    localparam int GridByteStep  = 60;

    localparam logic [15:0] ExposureReset = 16'h046B;
    localparam logic [15:0] AddrHold      = 16'h0104;
    localparam logic [15:0] AddrExpHigh   = 16'h0202;
    localparam logic [15:0] AddrExpLow    = 16'h0203;

    // Configuration register indexes.
    localparam logic [2:0] RegTargetLevel = 3'd0;
    localparam logic [2:0] RegBlackLevel  = 3'd1;
    localparam logic [2:0] RegPeriodShift = 3'd2;
    localparam logic [2:0] RegGainShift   = 3'd3;
    localparam logic [2:0] RegMaxStep     = 3'd4;
    localparam logic [2:0] RegExposureMin = 3'd5;
    localparam logic [2:0] RegExposureMax = 3'd6;

    // Position of a word inside the four-word sensor write group.
    localparam logic [1:0] WrHoldSet = 2'd0;
    localparam logic [1:0] WrExpHigh = 2'd1;
    localparam logic [1:0] WrExpLow  = 2'd2;
    localparam logic [1:0] WrHoldClr = 2'd3;

    typedef struct packed {
        logic [7:0]  target_level;
        logic [7:0]  black_level;
        logic [2:0]  period_shift;
        logic [2:0]  gain_shift;
        logic [9:0]  max_step;
        logic [15:0] exposure_min;
        logic [15:0] exposure_max;
    } cfg_t;

    // True when pos equals first + step * k for some k below GridCount.
    // The grid points are compared in parallel.
    function automatic logic on_grid(input logic [11:0] pos, input int first, input int step);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < GridCount; k++) begin
            hit = hit | (pos == 12'(first + step * k));
        end
        return hit;
    endfunction

endpackage

/* rtl/aer_update.sv */
// Exposure update datapath: mean, black level removal, proportional step,
// slew limit and clamp. Combinational; depends on aer_pkg.
module aer_update (
    input  aer_pkg::cfg_t                       cfg,
    input  logic [aer_pkg::SumWidth-1:0]        sample_sum,
    input  logic [15:0]                         exposure,
    output logic [15:0]                         new_exposure,
    output logic                                changed
);

    logic [7:0]         mean;
    logic [8:0]         mean_diff;
    logic [7:0]         mean8;
    logic signed [8:0]  err;
    logic signed [8:0]  delta;
    logic signed [10:0] delta_ext;
    logic signed [10:0] lim;
    logic signed [10:0] delta_lim;
    logic signed [17:0] cit;
    logic signed [17:0] cit_lo;
    logic signed [17:0] cit_hi;

    always_comb begin
        mean      = sample_sum[aer_pkg::SumWidth-1:aer_pkg::MeanShift];
        mean_diff = {1'b0, mean} - {1'b0, cfg.black_level};
        mean8     = mean_diff[8] ? 8'd0 : mean_diff[7:0];
        err       = $signed({1'b0, cfg.target_level}) - $signed({1'b0, mean8});
        delta     = err >>> cfg.gain_shift;

        delta_ext = 11'(delta);
        lim       = $signed({1'b0, cfg.max_step});
        if (delta_ext > lim) begin
            delta_lim = lim;
        end else if (delta_ext < -lim) begin
            delta_lim = -lim;
        end else begin
            delta_lim = delta_ext;
        end

        cit    = $signed({2'b00, exposure}) + 18'(delta_lim);
        // Lower bound first, then upper: the maximum wins when they cross.
        cit_lo = (cit < $signed({2'b00, cfg.exposure_min})) ?
                 $signed({2'b00, cfg.exposure_min}) : cit;
        cit_hi = (cit_lo > $signed({2'b00, cfg.exposure_max})) ?
                 $signed({2'b00, cfg.exposure_max}) : cit_lo;

        new_exposure = cit_hi[15:0];
        changed      = (new_exposure != exposure);
    end

endmodule

/* rtl/auto_exposure_regulator_unit.sv */
// Auto exposure regulator: samples a raw byte stream on a 32 x 32 grid and
// issues sensor exposure writes. Depends on aer_pkg and aer_update.
//
// Usage:
//   The s_ channel carries raw frame words (s_kind low) and frame-end words
//   (s_kind high). Each accepted word lands in an input register; a raw word is
//   processed in the next cycle, so one raw word per cycle is sustained while
//   no frame-end word waits there. Grid bytes are summed; at a frame end the
//   sum is cleared, the frame is counted and, on update frames, a new exposure
//   is formed. If the exposure changed, four words leave on the m_ channel:
//   hold set, exposure high byte, exposure low byte, hold clear (m_last high).
//   The frame-end word passes through the input register and then sets the
//   busy flag that offers the first result word. The burst counter holds one
//   group, so a following frame-end word waits in the input register until
//   the pending group's last word is taken; words behind it wait too, while
//   raw words ahead of it flow. When the receiver stalls, the current word
//   holds. Configuration is written through cfg_wr_en/cfg_index/cfg_data;
//   the user must write it only while idle, which the block does not enforce.
//   Reset (aresetn low, synchronous) restores register defaults, clears the
//   sum and frame count and sets the exposure to 1131 lines.
module auto_exposure_regulator_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [11:0] s_row,
    input  logic [11:0] s_byte_offset,
    input  logic [7:0]  s_pixel_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_reg_addr,
    output logic [7:0]  m_reg_value,
    output logic [15:0] m_exposure,
    output logic        m_last
);

    aer_pkg::cfg_t cfg_reg;

    logic        in_valid_reg;
    logic        kind_reg;
    logic [11:0] row_reg;
    logic [11:0] offset_reg;
    logic [7:0]  pixel_reg;

    logic [aer_pkg::SumWidth-1:0] sum_reg;
    logic [aer_pkg::SumWidth-1:0] sum_next;
    logic [7:0]  frame_count_reg;
    logic [7:0]  frame_count_next;
    logic [15:0] exposure_reg;
    logic        busy_reg;
    logic [1:0]  burst_idx_reg;

    logic        grid_hit;
    logic        burst_free;
    logic        last_fire;
    logic        proc_go;
    logic        byte_go;
    logic        frame_go;
    logic [7:0]  period_mask;
    logic        update_frame;
    logic [15:0] new_exposure;
    logic        exp_changed;
    logic        load_burst;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_level <= 8'd100;
            cfg_reg.black_level  <= 8'd16;
            cfg_reg.period_shift <= 3'd2;
            cfg_reg.gain_shift   <= 3'd3;
            cfg_reg.max_step     <= 10'd32;
            cfg_reg.exposure_min <= 16'd16;
            cfg_reg.exposure_max <= 16'd1180;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                aer_pkg::RegTargetLevel: cfg_reg.target_level <= cfg_data[7:0];
                aer_pkg::RegBlackLevel:  cfg_reg.black_level  <= cfg_data[7:0];
                aer_pkg::RegPeriodShift: cfg_reg.period_shift <= cfg_data[2:0];
                aer_pkg::RegGainShift:   cfg_reg.gain_shift   <= cfg_data[2:0];
                aer_pkg::RegMaxStep:     cfg_reg.max_step     <= cfg_data[9:0];
                aer_pkg::RegExposureMin: cfg_reg.exposure_min <= cfg_data;
                aer_pkg::RegExposureMax: cfg_reg.exposure_max <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A frame end may only proceed once the write group slot is free.
    assign last_fire  = busy_reg && m_ready && (burst_idx_reg == aer_pkg::WrHoldClr);
    assign burst_free = !busy_reg || last_fire;
    assign proc_go    = in_valid_reg && (!kind_reg || burst_free);
    assign byte_go    = proc_go && !kind_reg;
    assign frame_go   = proc_go && kind_reg;
    assign s_ready    = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg   <= s_kind;
            row_reg    <= s_row;
            offset_reg <= s_byte_offset;
            pixel_reg  <= s_pixel_byte;
        end
    end

    assign grid_hit =
        aer_pkg::on_grid(row_reg, aer_pkg::GridRowFirst, aer_pkg::GridRowStep) &&
        aer_pkg::on_grid(offset_reg, aer_pkg::GridByteFirst, aer_pkg::GridByteStep);

    always_comb begin
        sum_next = sum_reg;
        if (frame_go) begin
            sum_next = '0;
        end else if (byte_go && grid_hit) begin
            sum_next = sum_reg + {{(aer_pkg::SumWidth-8){1'b0}}, pixel_reg};
        end
    end

    assign frame_count_next = frame_count_reg + 8'd1;
    assign period_mask      = (8'd1 << cfg_reg.period_shift) - 8'd1;
    assign update_frame     = (frame_count_next & period_mask) == 8'd0;

    aer_update u_update (
        .cfg          (cfg_reg),
        .sample_sum   (sum_reg),
        .exposure     (exposure_reg),
        .new_exposure (new_exposure),
        .changed      (exp_changed)
    );

    assign load_burst = frame_go && update_frame && exp_changed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg         <= '0;
            frame_count_reg <= 8'd0;
            exposure_reg    <= aer_pkg::ExposureReset;
            busy_reg        <= 1'b0;
            burst_idx_reg   <= aer_pkg::WrHoldSet;
        end else begin
            sum_reg <= sum_next;
            if (frame_go) begin
                frame_count_reg <= frame_count_next;
            end
            if (load_burst) begin
                exposure_reg  <= new_exposure;
                busy_reg      <= 1'b1;
                burst_idx_reg <= aer_pkg::WrHoldSet;
            end else if (last_fire) begin
                busy_reg <= 1'b0;
            end else if (busy_reg && m_ready) begin
                burst_idx_reg <= burst_idx_reg + 2'd1;
            end
        end
    end

    always_comb begin
        unique case (burst_idx_reg)
            aer_pkg::WrHoldSet: begin
                m_reg_addr  = aer_pkg::AddrHold;
                m_reg_value = 8'd1;
            end
            aer_pkg::WrExpHigh: begin
                m_reg_addr  = aer_pkg::AddrExpHigh;
                m_reg_value = exposure_reg[15:8];
            end
            aer_pkg::WrExpLow: begin
                m_reg_addr  = aer_pkg::AddrExpLow;
                m_reg_value = exposure_reg[7:0];
            end
            default: begin
                m_reg_addr  = aer_pkg::AddrHold;
                m_reg_value = 8'd0;
            end
        endcase
    end

    assign m_valid    = busy_reg;
    assign m_exposure = exposure_reg;
    assign m_last     = (burst_idx_reg == aer_pkg::WrHoldClr);

    // A write group never opens while another one still has words pending.
    a_group_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_burst |-> (!busy_reg || last_fire))
        else $error("write group started over a pending group");

    // Once started, a write group runs until its last word is taken.
    a_group_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("write group ended before its last word");

    // The grid sum is cleared by every processed frame end.
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_go |=> (sum_reg == '0))
        else $error("sample sum not cleared at frame end");

    // A write group always begins with the hold-set word.
    a_group_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        load_burst |=> (m_valid && m_reg_addr == aer_pkg::AddrHold && m_reg_value == 8'd1))
        else $error("write group did not start with hold set");

endmodule
